// ----- hdl/pprx_pkg.sv -----
// pprx_pkg: shared types, codes and sizes for the parallel port receive fifo
// used by pprx_ctrl, pprx_datapath and parallel_port_rx_fifo_flow_control
package pprx_pkg;

    localparam int FIFO_DEPTH = 512;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int LVL_W      = 10;
    localparam int TMO_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // operation codes
    localparam logic [1:0] OP_STROBE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_LOCKED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODERATE_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 3'd4;

    localparam logic [LVL_W-1:0] MODERATE_RESET = 10'd307;
    localparam logic [LVL_W-1:0] CRITICAL_RESET = 10'd409;
    localparam logic [LVL_W-1:0] RECOVERY_RESET = 10'd256;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET  = 16'd5000;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] strobe_byte;
        logic       read_last;
    } in_item_t;

    typedef struct packed {
        logic             busy_res;
        logic             ack_pulse;
        logic             read_valid;
        logic [7:0]       read_byte;
        logic [CNT_W-1:0] fill_level;
        logic             critical_active;
        logic             overflow_drop;
        logic             timed_out;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic push;
        logic pop;
        logic tick;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

// ----- hdl/pprx_ctrl.sv -----
// pprx_ctrl: two-state sequencer, accept then execute one word
// depends on pprx_pkg
module pprx_ctrl
    import pprx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] operation,
    output logic       busy,
    output logic       done,
    output dp_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic       state_reg, state_next;
    logic [1:0] op_reg;
    logic       done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.capture = (state_reg == ST_IDLE) && start;
        if (state_reg == ST_EXEC)
        begin
            unique case (op_reg)
                OP_STROBE: cmd.push  = 1'b1;
                OP_READ:   cmd.pop   = 1'b1;
                OP_TICK:   cmd.tick  = 1'b1;
                OP_CLEAR:  cmd.clear = 1'b1;
                default:   cmd.clear = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_STROBE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EXEC);
            if (cmd.capture)
                op_reg <= operation;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

// ----- hdl/pprx_datapath.sv -----
// pprx_datapath: byte fifo memory, pointers, flow-control flags and config registers
// depends on pprx_pkg
module pprx_datapath
    import pprx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  dp_cmd_t   cmd,
    input  cfg_wr_t   cfg,
    output out_item_t result
);

    logic [7:0] mem [FIFO_DEPTH];
    logic [7:0] rdata_reg;

    logic [7:0]       data_reg;
    logic             last_reg;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_flag_reg, busy_flag_next;
    logic             crit_reg, crit_next;
    logic [TMO_W-1:0] elapsed_reg, elapsed_next;
    logic [TMO_W-1:0] elapsed_inc;
    logic             burst_reg, burst_next;
    logic             mem_we;

    logic             locked_reg;
    logic [LVL_W-1:0] moderate_reg, critical_reg, recovery_reg;
    logic [TMO_W-1:0] timeout_reg;

    out_item_t result_reg, result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg   <= 1'b0;
            moderate_reg <= MODERATE_RESET;
            critical_reg <= CRITICAL_RESET;
            recovery_reg <= RECOVERY_RESET;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PORT_LOCKED:    locked_reg   <= cfg.data[0];
                CFG_MODERATE_LEVEL: moderate_reg <= cfg.data[LVL_W-1:0];
                CFG_CRITICAL_LEVEL: critical_reg <= cfg.data[LVL_W-1:0];
                CFG_RECOVERY_LEVEL: recovery_reg <= cfg.data[LVL_W-1:0];
                CFG_TIMEOUT_MS:     timeout_reg  <= cfg.data[TMO_W-1:0];
                default:            ;
            endcase
        end
    end

    // head byte is read every cycle; writes only land in the execute cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_ptr_reg] <= data_reg;
        rdata_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            data_reg <= item.strobe_byte;
            last_reg <= item.read_last;
        end
    end

    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        busy_flag_next = busy_flag_reg;
        crit_next      = crit_reg;
        elapsed_next   = elapsed_reg;
        burst_next     = burst_reg;
        mem_we         = 1'b0;
        result_next    = '0;

        if (cmd.push && !locked_reg)
        begin
            if (count_reg >= CNT_W'(FIFO_DEPTH))
            begin
                busy_flag_next            = 1'b1;
                result_next.overflow_drop = 1'b1;
            end
            else
            begin
                mem_we                = 1'b1;
                wr_ptr_next           = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                        : wr_ptr_reg + 1'b1;
                count_next            = count_reg + 1'b1;
                result_next.ack_pulse = 1'b1;
                if (count_next >= critical_reg)
                begin
                    if (!crit_reg)
                    begin
                        crit_next    = 1'b1;
                        elapsed_next = '0;
                    end
                    busy_flag_next = 1'b1;
                end
                else if (crit_reg)
                begin
                    // critical hysteresis releases only below moderate
                    if (count_next < moderate_reg)
                    begin
                        crit_next      = 1'b0;
                        busy_flag_next = 1'b0;
                    end
                    else
                        busy_flag_next = 1'b1;
                end
                else
                    busy_flag_next = (count_next >= moderate_reg);
            end
        end

        if (cmd.pop)
        begin
            if (count_reg != '0)
            begin
                result_next.read_byte  = rdata_reg;
                result_next.read_valid = 1'b1;
                rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
                count_next  = count_reg - 1'b1;
                burst_next  = 1'b1;
            end
            if (last_reg)
            begin
                if (burst_next && (count_next < recovery_reg || count_next < moderate_reg))
                    busy_flag_next = 1'b0;
                burst_next = 1'b0;
            end
        end

        if (cmd.tick && crit_reg)
        begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= timeout_reg)
            begin
                rd_ptr_next           = '0;
                wr_ptr_next           = '0;
                count_next            = '0;
                crit_next             = 1'b0;
                elapsed_next          = '0;
                busy_flag_next        = 1'b0;
                result_next.timed_out = 1'b1;
            end
        end

        if (cmd.clear)
        begin
            rd_ptr_next    = '0;
            wr_ptr_next    = '0;
            count_next     = '0;
            busy_flag_next = 1'b0;
        end

        result_next.busy_res        = busy_flag_next;
        result_next.fill_level      = count_next;
        result_next.critical_active = crit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            busy_flag_reg <= 1'b0;
            crit_reg      <= 1'b0;
            elapsed_reg   <= '0;
            burst_reg     <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            busy_flag_reg <= busy_flag_next;
            crit_reg      <= crit_next;
            elapsed_reg   <= elapsed_next;
            burst_reg     <= burst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.pop || cmd.tick || cmd.clear)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- hdl/parallel_port_rx_fifo_flow_control.sv -----
// parallel_port_rx_fifo_flow_control: top level, controller plus datapath
// depends on pprx_pkg, pprx_ctrl, pprx_datapath
//
//  channel   handshake                  payload
//  input     start / busy               item   (in_item_t)
//  result    done (one-cycle strobe)    result (out_item_t)
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// each word is accepted, then executed in the execute state, which does the fifo
// access and threshold compares; the head byte comes from the registered read
// port of the 512 x 8 fifo memory, fetched during the accept edge
// the result strobes done in the cycle after execute, when busy is already low
// rst_n is asynchronous; the fifo is empty after reset with no clearing pass
// results cannot be held off; cfg_ready is always high
module parallel_port_rx_fifo_flow_control
    import pprx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    output logic                  done,
    output out_item_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    cfg_wr_t cfg;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    pprx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd)
    );

    pprx_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .cfg    (cfg),
        .result (result)
    );

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not enter execute");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execute cycle did not produce a result");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.fill_level <= CNT_W'(FIFO_DEPTH))
        else $error("fill level beyond fifo depth");

    a_timeout_flush: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.timed_out |-> result.fill_level == '0 && !result.critical_active
                                     && !result.busy_res)
        else $error("timeout did not flush the fifo");

endmodule

// ----- sim/parallel_port_rx_fifo_flow_control_tb.sv -----
`timescale 1ns / 1ps
// parallel_port_rx_fifo_flow_control_tb: self-checking bench for the parallel port receive fifo
// needs pprx_pkg and parallel_port_rx_fifo_flow_control; a directed table, then random
// strobe/read/tick/clear traffic under several threshold settings, checked by a software fifo
module parallel_port_rx_fifo_flow_control_tb;
    import pprx_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int N_PHASES = 7;
    localparam int MAX_PRINTS = 20;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    in_item_t              item = '0;
    logic                  done;
    out_item_t             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #1 clk = ~clk;

    parallel_port_rx_fifo_flow_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // software copy of the receive fifo and its flow control
    logic [7:0]       m_store [FIFO_DEPTH];
    logic [PTR_W-1:0] m_rd = '0;
    logic [PTR_W-1:0] m_wr = '0;
    logic [CNT_W-1:0] m_count = '0;
    logic             m_busy = 1'b0;
    logic             m_crit = 1'b0;
    logic [TMO_W-1:0] m_elapsed = '0;
    logic             m_popped = 1'b0;

    logic             c_locked = 1'b0;
    logic [LVL_W-1:0] c_moderate = MODERATE_RESET;
    logic [LVL_W-1:0] c_critical = CRITICAL_RESET;
    logic [LVL_W-1:0] c_recovery = RECOVERY_RESET;
    logic [TMO_W-1:0] c_timeout = TIMEOUT_RESET;

    out_item_t pending_results[$];
    in_item_t  word_plan[$];

    typedef struct packed {
        logic                  is_cfg;
        logic                  typed;
        in_item_t              w;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        out_item_t             res;
    } dir_row_t;

    dir_row_t dir_rows[$];

    int unsigned idle_pct = 22;
    int unsigned n_errors = 0;
    int unsigned n_words = 0;
    int unsigned n_checked = 0;
    int unsigned n_stored = 0;
    int unsigned n_pops = 0;
    int unsigned n_drops = 0;
    int unsigned n_timeouts = 0;

    int unsigned ph_locked  [N_PHASES] = '{0, 0, 0, 0, 1, 0, 0};
    int unsigned ph_moderate[N_PHASES] = '{307, 8, 0, 512, 5, 1023, 20};
    int unsigned ph_critical[N_PHASES] = '{409, 12, 0, 512, 3, 1, 30};
    int unsigned ph_recovery[N_PHASES] = '{256, 4, 0, 512, 10, 1023, 10};
    int unsigned ph_timeout [N_PHASES] = '{20, 3, 0, 65535, 1, 2, 7};
    int unsigned ph_words   [N_PHASES] = '{500, 300, 150, 500, 150, 200, 250};
    int unsigned ph_idle    [N_PHASES] = '{22, 22, 22, 49, 49, 0, 0};

    function automatic out_item_t rx_res(input logic bz, input logic ack, input logic vld,
                                         input logic [7:0] b, input logic [CNT_W-1:0] fill,
                                         input logic crit, input logic drop, input logic tmo);
        out_item_t r;
        r.busy_res        = bz;
        r.ack_pulse       = ack;
        r.read_valid      = vld;
        r.read_byte       = b;
        r.fill_level      = fill;
        r.critical_active = crit;
        r.overflow_drop   = drop;
        r.timed_out       = tmo;
        return r;
    endfunction

    // advances the software fifo by one word and returns what the block should answer
    function automatic out_item_t next_rx_result(input in_item_t w);
        out_item_t r;
        r = '0;
        case (w.operation)
            OP_STROBE:
            begin
                if (!c_locked)
                begin
                    if (m_count >= FIFO_DEPTH)
                    begin
                        m_busy = 1'b1;
                        r.overflow_drop = 1'b1;
                        n_drops++;
                    end
                    else
                    begin
                        m_store[m_wr] = w.strobe_byte;
                        m_wr = m_wr + 1'b1;
                        m_count = m_count + 1'b1;
                        r.ack_pulse = 1'b1;
                        n_stored++;
                        if (m_count >= c_critical)
                        begin
                            if (!m_crit)
                            begin
                                m_crit = 1'b1;
                                m_elapsed = '0;
                            end
                            m_busy = 1'b1;
                        end
                        else if (m_crit)
                        begin
                            // hysteresis: critical only lets go below the moderate level
                            if (m_count < c_moderate)
                            begin
                                m_crit = 1'b0;
                                m_busy = 1'b0;
                            end
                            else
                                m_busy = 1'b1;
                        end
                        else
                            m_busy = (m_count >= c_moderate);
                    end
                end
            end
            OP_READ:
            begin
                if (m_count != 0)
                begin
                    r.read_byte = m_store[m_rd];
                    r.read_valid = 1'b1;
                    m_rd = m_rd + 1'b1;
                    m_count = m_count - 1'b1;
                    m_popped = 1'b1;
                    n_pops++;
                end
                if (w.read_last)
                begin
                    if (m_popped && (m_count < c_recovery || m_count < c_moderate))
                        m_busy = 1'b0;
                    m_popped = 1'b0;
                end
            end
            OP_TICK:
            begin
                if (m_crit)
                begin
                    if (m_elapsed != '1)
                        m_elapsed = m_elapsed + 1'b1;
                    if (m_elapsed >= c_timeout)
                    begin
                        m_rd = '0;
                        m_wr = '0;
                        m_count = '0;
                        m_crit = 1'b0;
                        m_elapsed = '0;
                        m_busy = 1'b0;
                        r.timed_out = 1'b1;
                        n_timeouts++;
                    end
                end
            end
            default:
            begin
                m_rd = '0;
                m_wr = '0;
                m_count = '0;
                m_busy = 1'b0;
            end
        endcase
        r.busy_res = m_busy;
        r.fill_level = m_count;
        r.critical_active = m_crit;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("mismatch at result %0d: %s got %0h expected %0h", n_checked, what,
                     got, want);
    endtask

    task automatic check_result(input out_item_t got, input out_item_t want);
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
        if (got.ack_pulse !== want.ack_pulse)
            report_mismatch("ack_pulse", 16'(got.ack_pulse), 16'(want.ack_pulse));
        if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", 16'(got.read_valid), 16'(want.read_valid));
        if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", 16'(got.read_byte), 16'(want.read_byte));
        if (got.fill_level !== want.fill_level)
            report_mismatch("fill_level", 16'(got.fill_level), 16'(want.fill_level));
        if (got.critical_active !== want.critical_active)
            report_mismatch("critical_active", 16'(got.critical_active),
                            16'(want.critical_active));
        if (got.overflow_drop !== want.overflow_drop)
            report_mismatch("overflow_drop", 16'(got.overflow_drop), 16'(want.overflow_drop));
        if (got.timed_out !== want.timed_out)
            report_mismatch("timed_out", 16'(got.timed_out), 16'(want.timed_out));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", 16'(result.fill_level), 16'h0);
            else
                check_result(result, pending_results.pop_front());
            n_checked++;
        end
    end

    // one word through start/busy; start stays high into the next word unless we idle
    task automatic send_word(input in_item_t w, input logic typed, input out_item_t typed_res);
        out_item_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = next_rx_result(w);
        pending_results.push_back(typed ? typed_res : r);
        n_words++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // caller drops cfg_valid after the last write of a batch
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PORT_LOCKED:    c_locked   = data[0];
            CFG_MODERATE_LEVEL: c_moderate = data[LVL_W-1:0];
            CFG_CRITICAL_LEVEL: c_critical = data[LVL_W-1:0];
            CFG_RECOVERY_LEVEL: c_recovery = data[LVL_W-1:0];
            CFG_TIMEOUT_MS:     c_timeout  = data[TMO_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic dir_word(input logic [1:0] op, input logic [7:0] b, input logic last);
        dir_row_t row;
        row = '0;
        row.w.operation = op;
        row.w.strobe_byte = b;
        row.w.read_last = last;
        dir_rows.push_back(row);
    endtask

    task automatic dir_chk(input logic [1:0] op, input logic [7:0] b, input logic last,
                           input out_item_t res);
        dir_word(op, b, last);
        dir_rows[dir_rows.size() - 1].typed = 1'b1;
        dir_rows[dir_rows.size() - 1].res = res;
    endtask

    task automatic dir_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        dir_rows.push_back(row);
    endtask

    // random traffic in runs: fill runs, read bursts closed by read_last, tick runs,
    // clears, and a little noise with every field random
    task automatic plan_words();
        in_item_t    w;
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(99);
        w = '0;
        if (kind < 35)
        begin
            len = ($urandom_range(4) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
            begin
                w.operation = OP_STROBE;
                w.strobe_byte = 8'($urandom);
                w.read_last = 1'($urandom);
                word_plan.push_back(w);
            end
        end
        else if (kind < 62)
        begin
            len = ($urandom_range(4) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
            begin
                w.operation = OP_READ;
                w.strobe_byte = 8'($urandom);
                w.read_last = (i == len - 1) || ($urandom_range(15) == 0);
                word_plan.push_back(w);
            end
        end
        else if (kind < 77)
        begin
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
            begin
                w.operation = OP_TICK;
                w.strobe_byte = 8'($urandom);
                w.read_last = 1'($urandom);
                word_plan.push_back(w);
            end
        end
        else if (kind < 82)
        begin
            w.operation = OP_CLEAR;
            w.strobe_byte = 8'($urandom);
            w.read_last = 1'($urandom);
            word_plan.push_back(w);
        end
        else
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                w.operation = 2'($urandom);
                w.strobe_byte = 8'($urandom);
                w.read_last = 1'($urandom);
                word_plan.push_back(w);
            end
        end
    endtask

    initial
    begin
        int unsigned guard;
        int unsigned sent;
        in_item_t    w;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, thresholds at their reset values
        dir_chk(OP_READ,   8'h00, 1'b0, rx_res(1'b0, 1'b0, 1'b0, 8'h00, CNT_W'(0),
                                               1'b0, 1'b0, 1'b0));
        dir_chk(OP_READ,   8'hFF, 1'b1, rx_res(1'b0, 1'b0, 1'b0, 8'h00, CNT_W'(0),
                                               1'b0, 1'b0, 1'b0));
        dir_chk(OP_TICK,   8'h00, 1'b0, rx_res(1'b0, 1'b0, 1'b0, 8'h00, CNT_W'(0),
                                               1'b0, 1'b0, 1'b0));
        dir_chk(OP_CLEAR,  8'h00, 1'b0, rx_res(1'b0, 1'b0, 1'b0, 8'h00, CNT_W'(0),
                                               1'b0, 1'b0, 1'b0));
        dir_chk(OP_STROBE, 8'h00, 1'b0, rx_res(1'b0, 1'b1, 1'b0, 8'h00, CNT_W'(1),
                                               1'b0, 1'b0, 1'b0));
        dir_chk(OP_STROBE, 8'hFF, 1'b1, rx_res(1'b0, 1'b1, 1'b0, 8'h00, CNT_W'(2),
                                               1'b0, 1'b0, 1'b0));
        dir_chk(OP_READ,   8'h00, 1'b0, rx_res(1'b0, 1'b0, 1'b1, 8'h00, CNT_W'(1),
                                               1'b0, 1'b0, 1'b0));
        dir_chk(OP_READ,   8'h00, 1'b1, rx_res(1'b0, 1'b0, 1'b1, 8'hFF, CNT_W'(0),
                                               1'b0, 1'b0, 1'b0));
        dir_chk(OP_STROBE, 8'h5A, 1'b0, rx_res(1'b0, 1'b1, 1'b0, 8'h00, CNT_W'(1),
                                               1'b0, 1'b0, 1'b0));
        dir_chk(OP_CLEAR,  8'hFF, 1'b1, rx_res(1'b0, 1'b0, 1'b0, 8'h00, CNT_W'(0),
                                               1'b0, 1'b0, 1'b0));
        // tiny thresholds: warning, critical entry, hysteresis release, timeout
        dir_cfg(CFG_MODERATE_LEVEL, 16'd3);
        dir_cfg(CFG_CRITICAL_LEVEL, 16'd4);
        dir_cfg(CFG_RECOVERY_LEVEL, 16'd1);
        dir_cfg(CFG_TIMEOUT_MS, 16'd2);
        dir_word(OP_STROBE, 8'h11, 1'b0);
        dir_word(OP_STROBE, 8'h22, 1'b0);
        dir_word(OP_STROBE, 8'h33, 1'b0);
        dir_word(OP_STROBE, 8'h44, 1'b0);
        dir_word(OP_READ,   8'h00, 1'b0);
        dir_word(OP_READ,   8'h00, 1'b1);
        dir_word(OP_READ,   8'h00, 1'b0);
        dir_word(OP_STROBE, 8'h55, 1'b0);
        dir_word(OP_STROBE, 8'h66, 1'b0);
        dir_word(OP_STROBE, 8'h77, 1'b0);
        dir_word(OP_TICK,   8'h00, 1'b0);
        dir_word(OP_TICK,   8'h00, 1'b0);
        // locked port ignores the strobe
        dir_cfg(CFG_PORT_LOCKED, 16'd1);
        dir_word(OP_STROBE, 8'h88, 1'b0);
        // zero timeout fires on the first critical tick
        dir_cfg(CFG_PORT_LOCKED, 16'd0);
        dir_cfg(CFG_TIMEOUT_MS, 16'd0);
        dir_cfg(CFG_CRITICAL_LEVEL, 16'd1);
        dir_word(OP_STROBE, 8'h99, 1'b0);
        dir_word(OP_TICK,   8'h00, 1'b1);

        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].is_cfg)
            begin
                if (i == 0 || !dir_rows[i - 1].is_cfg)
                    wait_idle();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
                if (i + 1 == dir_rows.size() || !dir_rows[i + 1].is_cfg)
                    cfg_valid <= 1'b0;
            end
            else
                send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            cfg_write(CFG_PORT_LOCKED, 16'(ph_locked[p]));
            cfg_write(CFG_MODERATE_LEVEL, 16'(ph_moderate[p]));
            cfg_write(CFG_CRITICAL_LEVEL, 16'(ph_critical[p]));
            cfg_write(CFG_RECOVERY_LEVEL, 16'(ph_recovery[p]));
            cfg_write(CFG_TIMEOUT_MS, 16'(ph_timeout[p]));
            if (p == 4)
                cfg_write(CFG_UNUSED, 16'($urandom));
            cfg_valid <= 1'b0;
            idle_pct = ph_idle[p];
            word_plan.delete();
            sent = 0;
            while (sent < ph_words[p])
            begin
                if (word_plan.size() == 0)
                    plan_words();
                w = word_plan.pop_front();
                send_word(w, 1'b0, '0);
                sent++;
            end
        end

        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 16'(pending_results.size()), 16'h0);

        $display("%0d words over %0d threshold settings: %0d bytes stored, %0d popped,",
                 n_words, N_PHASES + 1, n_stored, n_pops);
        $display("%0d dropped on a full fifo, %0d critical timeouts, %0d mismatches",
                 n_drops, n_timeouts, n_errors);
        if (n_errors == 0)
            $display("parallel_port_rx_fifo_flow_control_tb: PASS");
        else
            $display("parallel_port_rx_fifo_flow_control_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("parallel_port_rx_fifo_flow_control_tb: FAIL");
        $finish;
    end

endmodule

// ----- parallel_port_rx_fifo_flow_control.f -----
hdl/pprx_pkg.sv
hdl/pprx_ctrl.sv
hdl/pprx_datapath.sv
hdl/parallel_port_rx_fifo_flow_control.sv
sim/parallel_port_rx_fifo_flow_control_tb.sv
